### hdl/lpb_pkg.sv
// Shared types and constants for the LRU page buffer pool.
package lpb_pkg;

  // Field widths
  localparam int PAGE_W       = 15;
  localparam int SLOT_OUT_W   = 3;

  // Default pool size
  localparam int POOL_SLOTS_DEF = 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the requested page
    logic lookup;    // compare tags, pick the target slot
    logic update;    // retag, reorder recency, load result registers
  } lpb_cmd_t;

endpackage

### hdl/lpb_ctrl.sv
// Sequencing controller for the LRU page buffer pool.
module lpb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output lpb_pkg::lpb_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == ST_UPD);
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = valid_r;
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.lookup  = (state_r == ST_LOOK);
  assign cmd.update  = (state_r == ST_UPD);

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_LOOK))
    else $error("accepted item did not enter lookup");

  a_look_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |=> (state_r == ST_UPD))
    else $error("lookup not followed by update");

  a_strobe_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(state_r == ST_UPD)))
    else $error("result strobe without a finished update");
`endif

endmodule

### hdl/lpb_datapath.sv
// Tag compare, recency ranks and result registers for the page buffer pool.
module lpb_datapath #(
  parameter int POOL_SLOTS = lpb_pkg::POOL_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpb_pkg::lpb_cmd_t             cmd,
  input  logic [lpb_pkg::PAGE_W-1:0]    in_page_number,
  output logic                          out_hit,
  output logic [lpb_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic                          out_writeback,
  output logic [lpb_pkg::PAGE_W-1:0]    out_evicted_page
);

  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int PW = lpb_pkg::PAGE_W;
  localparam int OW = lpb_pkg::SLOT_OUT_W;

  // Per-slot cells: page tag and recency rank (0 = most recent)
  logic [PW-1:0] tag_r  [POOL_SLOTS];
  logic [SW-1:0] rank_r [POOL_SLOTS];
  logic [CW-1:0] used_r;

  // Request and lookup registers
  logic [PW-1:0] page_r;
  logic          hit_r;
  logic          wb_r;
  logic          fill_r;
  logic [SW-1:0] tgt_r;
  logic [SW-1:0] pos_r;
  logic [PW-1:0] evict_r;

  // Result registers
  logic          res_hit_r;
  logic [SW-1:0] res_slot_r;
  logic          res_wb_r;
  logic [PW-1:0] res_evict_r;

  logic [POOL_SLOTS-1:0] occ;
  logic [POOL_SLOTS-1:0] match;
  logic [POOL_SLOTS-1:0] lru;
  logic                  hit_c;
  logic                  full_c;
  logic [SW-1:0]         hit_slot_c;
  logic [SW-1:0]         hit_rank_c;
  logic [SW-1:0]         lru_slot_c;
  logic [PW-1:0]         lru_tag_c;
  logic [SW-1:0]         tgt_nxt;
  logic [SW-1:0]         pos_nxt;
  logic [SW+OW-1:0]      slot_ext;

  // Parallel tag compare and LRU slot select
  always_comb begin
    hit_slot_c = '0;
    hit_rank_c = '0;
    lru_slot_c = '0;
    lru_tag_c  = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      occ[i]   = (CW'(i) < used_r);
      match[i] = occ[i] && (tag_r[i] == page_r);
      lru[i]   = occ[i] && (rank_r[i] == SW'(POOL_SLOTS - 1));
      if (match[i]) begin
        hit_slot_c = hit_slot_c | SW'(i);
        hit_rank_c = hit_rank_c | rank_r[i];
      end
      if (lru[i]) begin
        lru_slot_c = lru_slot_c | SW'(i);
        lru_tag_c  = lru_tag_c | tag_r[i];
      end
    end
    hit_c  = |match;
    full_c = (used_r == CW'(POOL_SLOTS));
  end

  // Target slot and its old recency position
  always_comb begin
    if (hit_c) begin
      tgt_nxt = hit_slot_c;
      pos_nxt = hit_rank_c;
    end else if (full_c) begin
      tgt_nxt = lru_slot_c;
      pos_nxt = SW'(POOL_SLOTS - 1);
    end else begin
      tgt_nxt = used_r[SW-1:0];
      pos_nxt = used_r[SW-1:0];
    end
  end

  // Request capture and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_page_number;
    end
    if (cmd.lookup) begin
      hit_r   <= hit_c;
      wb_r    <= !hit_c && full_c;
      fill_r  <= !hit_c && !full_c;
      tgt_r   <= tgt_nxt;
      pos_r   <= pos_nxt;
      evict_r <= (!hit_c && full_c) ? lru_tag_c : '0;
    end
  end

  // Slot cells: retag target, move it to the front, age the ones ahead of it
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (SW'(i) == tgt_r) begin
          tag_r[i]  <= page_r;
          rank_r[i] <= '0;
        end else if (occ[i] && (rank_r[i] < pos_r)) begin
          rank_r[i] <= rank_r[i] + SW'(1);
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.update && fill_r) begin
      used_r <= used_r + CW'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_hit_r   <= hit_r;
      res_slot_r  <= tgt_r;
      res_wb_r    <= wb_r;
      res_evict_r <= evict_r;
    end
  end

  assign slot_ext         = (SW + OW)'(res_slot_r);
  assign out_hit          = res_hit_r;
  assign out_slot         = slot_ext[OW-1:0];
  assign out_writeback    = res_wb_r;
  assign out_evicted_page = res_evict_r;

`ifndef SYNTHESIS
  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(POOL_SLOTS))
    else $error("fill count beyond pool size");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.update) |-> !(res_hit_r && res_wb_r))
    else $error("hit reported together with write-back");

  a_fill_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && fill_r) |-> (used_r < CW'(POOL_SLOTS)))
    else $error("new slot taken from a full pool");
`endif

endmodule

### hdl/lru_page_buffer_pool_top.sv
// An accepted item passes through the lookup and update states; the result strobe is registered from update.
// A new item is accepted only while idle; busy covers the lookup and update steps.
// Lookup compares all slot tags in parallel; update retags the target and ages ranks.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (rst_n low, synchronous) empties the pool and idles the controller.
// Top level of the LRU page buffer pool.
module lru_page_buffer_pool_top #(
  parameter int POOL_SLOTS = lpb_pkg::POOL_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpb_pkg::PAGE_W-1:0]     in_page_number,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic [lpb_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic                           out_writeback,
  output logic [lpb_pkg::PAGE_W-1:0]     out_evicted_page
);

  lpb_pkg::lpb_cmd_t cmd;

  // Controller
  lpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath
  lpb_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_page_number   (in_page_number),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_writeback    (out_writeback),
    .out_evicted_page (out_evicted_page)
  );

endmodule
